// ----- hdl/bthc_pkg.sv -----
// Shared types and constants for the button tap/hold classifier.
package bthc_pkg;

    // Button count; one cell per button, scan covers at most 16
    localparam int NUM_BUTTONS = 16;
    localparam int BTN_W       = 4;
    localparam int TIME_W      = 32;
    localparam int THR_W       = 16;
    localparam int MASK_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int NUM_CELLS   = (NUM_BUTTONS < 16) ? NUM_BUTTONS : 16;

    // Request opcodes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_DOWN = 2'd1;
    localparam logic [1:0] OP_UP   = 2'd2;

    // Event kinds
    localparam logic [1:0] KIND_HELD     = 2'd0;
    localparam logic [1:0] KIND_SINGLE   = 2'd1;
    localparam logic [1:0] KIND_RELEASED = 2'd2;
    localparam logic [1:0] KIND_RAW      = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK     = 2'd2;

    // Reset values
    localparam logic [THR_W-1:0]  HOLD_THR_RST = 16'd500;
    localparam logic [MASK_W-1:0] MASK_RST     = 16'hE55F;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    // Commands broadcast from the controller to every cell
    typedef struct packed {
        logic wr_press;  // selected cell records a press
        logic clr;       // selected cell drops its press
        logic eval;      // all cells latch their hold-due flag
        logic adv;       // scan token moves one cell on
    } cell_cmd_t;

endpackage

// ----- hdl/bthc_if.sv -----
// Request and event channel interfaces.
interface bthc_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 opcode;
    logic [bthc_pkg::BTN_W-1:0] button_index;
    logic [bthc_pkg::TIME_W-1:0] now_ms;

    modport source (output valid, output opcode, output button_index, output now_ms,
                    input ready);
    modport sink   (input valid, input opcode, input button_index, input now_ms,
                    output ready);
endinterface

interface bthc_out_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 event_kind;
    logic [bthc_pkg::BTN_W-1:0] event_button;
    logic                       last_of_run;

    modport source (output valid, output event_kind, output event_button,
                    output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input event_button,
                    input last_of_run, output ready);
endinterface

// ----- hdl/bthc_cell.sv -----
// One button cell: press time, flags, hold-due flag and scan token.
module bthc_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bthc_pkg::cell_cmd_t           cmd,
    input  logic                          sel,
    input  logic [bthc_pkg::TIME_W-1:0]   now_ms,
    input  logic [bthc_pkg::THR_W-1:0]    hold_thr,
    input  logic                          tok_in,
    input  logic                          rest_in,
    output logic                          tok_out,
    output logic                          rest_out,
    output logic                          hit,
    output logic                          hit_last,
    output logic [bthc_pkg::TIME_W-1:0]   start_ms
);

    logic [bthc_pkg::TIME_W-1:0] stamp_reg, stamp_next;
    logic                        pressed_reg, pressed_next;
    logic                        held_reg, held_next;
    logic                        due_reg, due_next;
    logic                        tok_reg, tok_next;
    logic [bthc_pkg::TIME_W-1:0] age;

    // Wrapping age of the open press
    assign age = now_ms - stamp_reg;

    // Scan outputs: token sits here and a hold is due
    assign hit      = tok_reg & due_reg;
    assign hit_last = hit & ~rest_in;
    assign rest_out = due_reg | rest_in;
    assign tok_out  = tok_reg;
    assign start_ms = pressed_reg ? stamp_reg : '0;

    // Next state
    always_comb
    begin
        stamp_next   = stamp_reg;
        pressed_next = pressed_reg;
        held_next    = held_reg;
        due_next     = due_reg;
        tok_next     = tok_reg;
        if (cmd.eval)
        begin
            due_next = pressed_reg & ~held_reg &
                       (age >= {{(bthc_pkg::TIME_W-bthc_pkg::THR_W){1'b0}}, hold_thr});
        end
        if (cmd.adv)
        begin
            tok_next = tok_in;
            if (hit)
            begin
                held_next = 1'b1;
            end
        end
        if (sel && cmd.wr_press)
        begin
            stamp_next   = now_ms;
            pressed_next = 1'b1;
            held_next    = 1'b0;
        end
        if (sel && cmd.clr)
        begin
            stamp_next   = '0;
            pressed_next = 1'b0;
            held_next    = 1'b0;
        end
    end

    // Cell registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg   <= '0;
            pressed_reg <= 1'b0;
            held_reg    <= 1'b0;
            due_reg     <= 1'b0;
            tok_reg     <= 1'b0;
        end
        else
        begin
            stamp_reg   <= stamp_next;
            pressed_reg <= pressed_next;
            held_reg    <= held_next;
            due_reg     <= due_next;
            tok_reg     <= tok_next;
        end
    end

endmodule

// ----- hdl/button_tap_hold_classifier_unit.sv -----
// Top level of the button tap/hold classifier: controller, cell row, event register.
// Each button owns one cell in a row of 16; a tick first has every cell check its
// press age against the hold threshold at once, then a scan token walks the row
// one cell per cycle, stalling on a due cell while the event register is full, and
// each due cell hands out one held event. Down and up requests that emit an event
// likewise wait while the event register is full. A new request is taken only
// when the previous one is finished; the event register decouples the output
// side, so a pending event does not hold off the next request. After reset
// the threshold is 500 ms, detection mode is off, the mapped mask is 0xE55F and
// no press is open. Configuration writes must come while the block is idle.
module button_tap_hold_classifier_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    bthc_in_if.sink                           req,
    bthc_out_if.source                        evt,
    input  logic                              cfg_we,
    input  logic [bthc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bthc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int N = bthc_pkg::NUM_CELLS;

    bthc_pkg::state_t             state_reg, state_next;
    logic [1:0]                   op_reg;
    logic [bthc_pkg::BTN_W-1:0]   idx_reg;
    logic [bthc_pkg::TIME_W-1:0]  now_reg;

    logic [bthc_pkg::THR_W-1:0]   thr_reg;
    logic                         detect_reg;
    logic [bthc_pkg::MASK_W-1:0]  mask_reg;

    logic                         out_valid_reg, out_valid_next;
    logic [1:0]                   kind_reg;
    logic [bthc_pkg::BTN_W-1:0]   btn_reg;
    logic                         last_reg;

    logic                         emit;
    logic [1:0]                   emit_kind;
    logic [bthc_pkg::BTN_W-1:0]   emit_btn;
    logic                         emit_last;

    bthc_pkg::cell_cmd_t          cmd;
    logic                         tok_start;
    logic [N-1:0]                 sel;
    logic [N:0]                   tok_chain;
    logic [N:0]                   rest_chain;
    logic [N-1:0]                 hit;
    logic [N-1:0]                 hit_last;
    logic [bthc_pkg::TIME_W-1:0]  start_ms [N];

    logic                         slot_free;
    logic                         mapped;
    logic [bthc_pkg::TIME_W-1:0]  dur;
    logic [bthc_pkg::TIME_W-1:0]  start_sel;
    logic [bthc_pkg::BTN_W-1:0]   hit_idx;

    // Channel outputs
    assign req.ready        = (state_reg == bthc_pkg::ST_IDLE);
    assign evt.valid        = out_valid_reg;
    assign evt.event_kind   = kind_reg;
    assign evt.event_button = btn_reg;
    assign evt.last_of_run  = last_reg;

    assign slot_free = ~out_valid_reg | evt.ready;

    // Cell row: token runs up from cell 0, pending-due flags run down
    assign tok_chain[0]  = tok_start;
    assign rest_chain[N] = 1'b0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        assign sel[i] = (idx_reg == bthc_pkg::BTN_W'(i));

        bthc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .sel      (sel[i]),
            .now_ms   (now_reg),
            .hold_thr (thr_reg),
            .tok_in   (tok_chain[i]),
            .rest_in  (rest_chain[i+1]),
            .tok_out  (tok_chain[i+1]),
            .rest_out (rest_chain[i]),
            .hit      (hit[i]),
            .hit_last (hit_last[i]),
            .start_ms (start_ms[i])
        );
    end

    // Button lookups for the addressed cell
    always_comb
    begin
        mapped    = 1'b0;
        start_sel = '0;
        for (int i = 0; i < N; i++)
        begin
            if (sel[i])
            begin
                mapped    = mask_reg[i];
                start_sel = start_ms[i];
            end
        end
    end

    assign dur = now_reg - start_sel;

    // Index of the cell holding the token with a due hold
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < N; i++)
        begin
            if (hit[i])
            begin
                hit_idx = hit_idx | bthc_pkg::BTN_W'(i);
            end
        end
    end

    // Controller: next state, cell commands and event emission
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        tok_start    = 1'b0;
        emit         = 1'b0;
        emit_kind    = bthc_pkg::KIND_HELD;
        emit_btn     = idx_reg;
        emit_last    = 1'b1;
        unique case (state_reg)
            bthc_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = bthc_pkg::ST_EXEC;
                end
            end
            bthc_pkg::ST_EXEC:
            begin
                unique case (op_reg)
                    bthc_pkg::OP_TICK:
                    begin
                        cmd.eval   = 1'b1;
                        cmd.adv    = 1'b1;
                        tok_start  = 1'b1;
                        state_next = bthc_pkg::ST_SCAN;
                    end
                    bthc_pkg::OP_DOWN:
                    begin
                        if (detect_reg)
                        begin
                            if (slot_free)
                            begin
                                emit       = 1'b1;
                                emit_kind  = bthc_pkg::KIND_RAW;
                                state_next = bthc_pkg::ST_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.wr_press = mapped;
                            state_next   = bthc_pkg::ST_IDLE;
                        end
                    end
                    bthc_pkg::OP_UP:
                    begin
                        if (!detect_reg && mapped)
                        begin
                            if (slot_free)
                            begin
                                emit       = 1'b1;
                                emit_kind  = (dur < {{(bthc_pkg::TIME_W-bthc_pkg::THR_W){1'b0}},
                                                     thr_reg})
                                             ? bthc_pkg::KIND_SINGLE
                                             : bthc_pkg::KIND_RELEASED;
                                cmd.clr    = 1'b1;
                                state_next = bthc_pkg::ST_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = bthc_pkg::ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = bthc_pkg::ST_IDLE;
                    end
                endcase
            end
            bthc_pkg::ST_SCAN:
            begin
                // Token stalls on a due cell until the event register frees up
                cmd.adv = ~(|hit) | slot_free;
                if ((|hit) && slot_free)
                begin
                    emit      = 1'b1;
                    emit_kind = bthc_pkg::KIND_HELD;
                    emit_btn  = hit_idx;
                    emit_last = |hit_last;
                end
                if (cmd.adv && tok_chain[N])
                begin
                    state_next = bthc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bthc_pkg::ST_IDLE;
            end
        endcase
    end

    // Event register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (evt.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bthc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            thr_reg       <= bthc_pkg::HOLD_THR_RST;
            detect_reg    <= 1'b0;
            mask_reg      <= bthc_pkg::MASK_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    bthc_pkg::CFG_HOLD_THR: thr_reg    <= cfg_data[bthc_pkg::THR_W-1:0];
                    bthc_pkg::CFG_DETECT:   detect_reg <= cfg_data[0];
                    bthc_pkg::CFG_MASK:     mask_reg   <= cfg_data[bthc_pkg::MASK_W-1:0];
                    default:                ;
                endcase
            end
        end
    end

    // Request and event payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg  <= req.opcode;
            idx_reg <= req.button_index;
            now_reg <= req.now_ms;
        end
        if (emit)
        begin
            kind_reg <= emit_kind;
            btn_reg  <= emit_btn;
            last_reg <= emit_last;
        end
    end

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the button tap/hold classifier unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         SETTLE_CYC  = 40;
    localparam int         RAND_PHASES = 5;
    localparam int         PHASE_ITEMS = 48;

    typedef struct packed {
        logic [1:0]                  op;
        logic [bthc_pkg::BTN_W-1:0]  button;
        logic [bthc_pkg::TIME_W-1:0] now;
    } button_request_t;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [bthc_pkg::BTN_W-1:0] button;
        logic                       last;
    } button_event_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [bthc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bthc_pkg::CFG_DATA_W-1:0] cfg_data;

    bthc_in_if  req_if ();
    bthc_out_if evt_if ();

    button_request_t pending_requests[$];
    button_event_t   expected_events[$];
    int              mismatches;

    // Shadow of the block's press state and configuration
    logic [bthc_pkg::TIME_W-1:0]      press_time [bthc_pkg::NUM_BUTTONS];
    logic [bthc_pkg::NUM_BUTTONS-1:0] open_press;
    logic [bthc_pkg::NUM_BUTTONS-1:0] hold_reported;
    logic [bthc_pkg::THR_W-1:0]       hold_thr;
    logic                             det_mode;
    logic [bthc_pkg::MASK_W-1:0]      btn_mask;

    // Driver and monitor bookkeeping
    int              req_gap;
    int              req_calm;
    int              evt_stall;
    int              evt_calm;
    button_request_t req_next;
    button_event_t   evt_want;

    button_tap_hold_classifier_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .evt       (evt_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length: mostly short, a few long, with calm stretches of none
    function automatic int idle_length(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm = $urandom_range(20, 60);
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Work out the events one accepted request causes
    task automatic classify_request(input logic [1:0] op,
                                    input logic [bthc_pkg::BTN_W-1:0] b,
                                    input logic [bthc_pkg::TIME_W-1:0] now);
        button_event_t               ev;
        logic [bthc_pkg::TIME_W-1:0] age;
        logic [bthc_pkg::TIME_W-1:0] start;
        logic                        mapped;
        int                          count;
        count     = 0;
        ev.last   = 1'b0;
        mapped    = (int'(b) < bthc_pkg::NUM_CELLS) && btn_mask[b];
        case (op)
            bthc_pkg::OP_TICK:
            begin
                for (int i = 0; i < bthc_pkg::NUM_CELLS; i++)
                begin
                    if (open_press[i] && !hold_reported[i])
                    begin
                        age = now - press_time[i];
                        if (age >= bthc_pkg::TIME_W'(hold_thr))
                        begin
                            ev.kind   = bthc_pkg::KIND_HELD;
                            ev.button = bthc_pkg::BTN_W'(i);
                            expected_events.push_back(ev);
                            count++;
                            hold_reported[i] = 1'b1;
                        end
                    end
                end
            end
            bthc_pkg::OP_DOWN:
            begin
                if (det_mode)
                begin
                    ev.kind   = bthc_pkg::KIND_RAW;
                    ev.button = b;
                    expected_events.push_back(ev);
                    count++;
                end
                else if (mapped)
                begin
                    press_time[b]    = now;
                    open_press[b]    = 1'b1;
                    hold_reported[b] = 1'b0;
                end
            end
            bthc_pkg::OP_UP:
            begin
                if (!det_mode && mapped)
                begin
                    start     = open_press[b] ? press_time[b] : '0;
                    age       = now - start;
                    ev.kind   = (age < bthc_pkg::TIME_W'(hold_thr))
                                ? bthc_pkg::KIND_SINGLE : bthc_pkg::KIND_RELEASED;
                    ev.button = b;
                    expected_events.push_back(ev);
                    count++;
                    press_time[b]    = '0;
                    open_press[b]    = 1'b0;
                    hold_reported[b] = 1'b0;
                end
            end
            default:
                ;
        endcase
        if (count > 0)
            expected_events[$].last = 1'b1;
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid        <= 1'b0;
            req_if.opcode       <= bthc_pkg::OP_TICK;
            req_if.button_index <= '0;
            req_if.now_ms       <= '0;
            req_gap  = 0;
            req_calm = 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
                classify_request(req_if.opcode, req_if.button_index, req_if.now_ms);
            if (!req_if.valid || req_if.ready)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_if.valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    req_next = pending_requests.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.opcode       <= req_next.op;
                    req_if.button_index <= req_next.button;
                    req_if.now_ms       <= req_next.now;
                    req_gap = idle_length(req_calm);
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // Event monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_if.ready <= 1'b0;
            evt_stall = 0;
            evt_calm  = 0;
        end
        else
        begin
            if (evt_if.valid && evt_if.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected event: expected none, got %s",
                             $time,
                             $sformatf("kind=%0d button=%0d last=%0d",
                                       evt_if.event_kind, evt_if.event_button,
                                       evt_if.last_of_run));
                end
                else
                begin
                    evt_want = expected_events.pop_front();
                    if (evt_if.event_kind !== evt_want.kind
                        || evt_if.event_button !== evt_want.button
                        || evt_if.last_of_run !== evt_want.last)
                    begin
                        mismatches++;
                        $display("%0t: event mismatch: expected %s, got %s",
                                 $time,
                                 $sformatf("kind=%0d button=%0d last=%0d",
                                           evt_want.kind, evt_want.button,
                                           evt_want.last),
                                 $sformatf("kind=%0d button=%0d last=%0d",
                                           evt_if.event_kind, evt_if.event_button,
                                           evt_if.last_of_run));
                    end
                end
                evt_stall = idle_length(evt_calm);
            end
            if (evt_stall > 0)
            begin
                evt_stall--;
                evt_if.ready <= 1'b0;
            end
            else
                evt_if.ready <= 1'b1;
        end
    end

    task automatic push_request(input logic [1:0] op,
                                input logic [bthc_pkg::BTN_W-1:0] b,
                                input logic [bthc_pkg::TIME_W-1:0] now);
        button_request_t item;
        item.op     = op;
        item.button = b;
        item.now    = now;
        pending_requests.push_back(item);
    endtask

    // Write one register; the block is idle whenever this is called
    task automatic write_reg(input logic [bthc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bthc_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            bthc_pkg::CFG_HOLD_THR: hold_thr = data[bthc_pkg::THR_W-1:0];
            bthc_pkg::CFG_DETECT:   det_mode = data[0];
            bthc_pkg::CFG_MASK:     btn_mask = data[bthc_pkg::MASK_W-1:0];
            default:                ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every request is taken and every event has come, then let a scan finish
    task automatic wait_idle();
        @(negedge clk);
        while (pending_requests.size() != 0 || req_if.valid || expected_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        @(negedge clk);
    endtask

    // Stimulus and end of run
    initial
    begin
        logic [bthc_pkg::TIME_W-1:0]      clock_ms;
        logic [bthc_pkg::NUM_BUTTONS-1:0] open_btns;
        logic [bthc_pkg::BTN_W-1:0]       btn;
        logic [bthc_pkg::THR_W-1:0]       thr_sel;
        logic [bthc_pkg::MASK_W-1:0]      mask_sel;
        logic                             det_sel;
        int                               r;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        req_if.valid        = 1'b0;
        req_if.opcode       = bthc_pkg::OP_TICK;
        req_if.button_index = '0;
        req_if.now_ms       = '0;
        evt_if.ready        = 1'b0;
        mismatches          = 0;
        for (int i = 0; i < bthc_pkg::NUM_BUTTONS; i++)
            press_time[i] = '0;
        open_press    = '0;
        hold_reported = '0;
        hold_thr      = bthc_pkg::HOLD_THR_RST;
        det_mode      = 1'b0;
        btn_mask      = bthc_pkg::MASK_RST;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: empty tick, up without down, holds, repeated down, wrap
        push_request(bthc_pkg::OP_TICK, 4'd0, 32'd0);
        push_request(bthc_pkg::OP_UP, 4'd0, 32'd100);
        push_request(bthc_pkg::OP_UP, 4'd1, 32'hFFFF_FFFF);
        push_request(bthc_pkg::OP_DOWN, 4'd0, 32'd1000);
        push_request(bthc_pkg::OP_DOWN, 4'd1, 32'd1000);
        push_request(bthc_pkg::OP_DOWN, 4'd15, 32'd1000);
        push_request(bthc_pkg::OP_DOWN, 4'd5, 32'd1000);
        push_request(bthc_pkg::OP_TICK, 4'd0, 32'd1499);
        push_request(bthc_pkg::OP_TICK, 4'd0, 32'd1500);
        push_request(bthc_pkg::OP_TICK, 4'd0, 32'd1600);
        push_request(bthc_pkg::OP_DOWN, 4'd0, 32'd1700);
        push_request(bthc_pkg::OP_TICK, 4'd0, 32'd2200);
        push_request(bthc_pkg::OP_UP, 4'd1, 32'd2300);
        push_request(bthc_pkg::OP_UP, 4'd0, 32'd2250);
        push_request(bthc_pkg::OP_UP, 4'd15, 32'd1200);
        push_request(bthc_pkg::OP_UP, 4'd5, 32'd1300);
        push_request(OP_UNUSED, 4'd10, 32'hAAAA_5555);
        push_request(bthc_pkg::OP_DOWN, 4'd2, 32'hFFFF_FF00);
        push_request(bthc_pkg::OP_TICK, 4'd0, 32'h0000_0100);
        push_request(bthc_pkg::OP_UP, 4'd2, 32'h0000_0010);
        push_request(bthc_pkg::OP_DOWN, 4'd3, 32'd5000);
        push_request(bthc_pkg::OP_DOWN, 4'd4, 32'd5000);
        wait_idle();

        // Detection mode with an empty mask: raw presses, ups ignored, open presses still held
        write_reg(bthc_pkg::CFG_HOLD_THR, 16'd1);
        write_reg(bthc_pkg::CFG_DETECT, 16'd1);
        write_reg(bthc_pkg::CFG_MASK, 16'h0000);
        @(negedge clk);
        push_request(bthc_pkg::OP_DOWN, 4'd7, 32'd5000);
        push_request(bthc_pkg::OP_DOWN, 4'd3, 32'd5000);
        push_request(bthc_pkg::OP_UP, 4'd3, 32'd5000);
        push_request(bthc_pkg::OP_TICK, 4'd0, 32'd5000);
        push_request(bthc_pkg::OP_TICK, 4'd0, 32'd5001);
        wait_idle();

        // Normal mode, still unmapped: the open press on button 4 cannot be released
        write_reg(bthc_pkg::CFG_DETECT, 16'd0);
        @(negedge clk);
        push_request(bthc_pkg::OP_UP, 4'd4, 32'd6000);
        push_request(bthc_pkg::OP_DOWN, 4'd4, 32'd6000);
        wait_idle();

        // Largest threshold, everything mapped
        write_reg(bthc_pkg::CFG_HOLD_THR, 16'hFFFF);
        write_reg(bthc_pkg::CFG_MASK, 16'hFFFF);
        @(negedge clk);
        push_request(bthc_pkg::OP_UP, 4'd3, 32'd5000 + 32'd65534);
        push_request(bthc_pkg::OP_UP, 4'd4, 32'd5000 + 32'd65535);
        wait_idle();

        // Random phases: mostly press traffic around the threshold, some noise
        clock_ms  = $urandom();
        open_btns = '0;
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            if (phase == 0)
                thr_sel = 16'd1;
            else if (phase == 1)
                thr_sel = 16'hFFFF;
            else if ($urandom_range(0, 1) == 0)
                thr_sel = bthc_pkg::THR_W'($urandom_range(2, 300));
            else
                thr_sel = bthc_pkg::THR_W'($urandom_range(1, 65535));
            case ($urandom_range(0, 3))
                0:       mask_sel = 16'hFFFF;
                1:       mask_sel = bthc_pkg::MASK_RST;
                default: mask_sel = bthc_pkg::MASK_W'($urandom());
            endcase
            if (phase == 4)
                mask_sel = 16'h0000;
            det_sel = (phase == 3) || ($urandom_range(0, 5) == 0);
            write_reg(bthc_pkg::CFG_HOLD_THR, thr_sel);
            write_reg(bthc_pkg::CFG_MASK, mask_sel);
            write_reg(bthc_pkg::CFG_DETECT, {15'd0, det_sel});
            @(negedge clk);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    clock_ms += $urandom_range(0, 32'd3 * hold_thr);
                else
                    clock_ms += $urandom_range(0, hold_thr);
                r   = $urandom_range(0, 99);
                btn = bthc_pkg::BTN_W'($urandom_range(0, bthc_pkg::NUM_BUTTONS - 1));
                if (r < 5)
                begin
                    clock_ms = $urandom();
                    push_request(bthc_pkg::OP_TICK, btn, clock_ms);
                end
                else if (r < 32)
                begin
                    if (btn_mask != '0 && $urandom_range(0, 4) != 0)
                        while (!btn_mask[btn])
                            btn = bthc_pkg::BTN_W'($urandom_range(0,
                                                   bthc_pkg::NUM_BUTTONS - 1));
                    if (!det_mode && btn_mask[btn])
                        open_btns[btn] = 1'b1;
                    push_request(bthc_pkg::OP_DOWN, btn, clock_ms);
                end
                else if (r < 57)
                begin
                    if (open_btns != '0 && $urandom_range(0, 5) != 0)
                        while (!open_btns[btn])
                            btn = bthc_pkg::BTN_W'($urandom_range(0,
                                                   bthc_pkg::NUM_BUTTONS - 1));
                    if (!det_mode && btn_mask[btn])
                        open_btns[btn] = 1'b0;
                    push_request(bthc_pkg::OP_UP, btn, clock_ms);
                end
                else if (r < 90)
                    push_request(bthc_pkg::OP_TICK, btn, clock_ms);
                else
                    push_request(2'($urandom_range(0, 3)), btn, $urandom());
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #15_000_000;
        $display("%0t: timeout with %0d requests pending and %0d events expected",
                 $time, pending_requests.size(), expected_events.size());
        $display("simulation failed");
        $finish;
    end

endmodule
